/* hdl/uart_rm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_rm_pkg
// shared types and constants for the reduced 16550-style register block
// ----------------------------------------------------------------------------
package uart_rm_pkg;

  // request kinds carried on the input tuser
  localparam logic [1:0] REQ_READ  = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_RX    = 2'd2;

  // access sizes
  localparam logic [1:0] SIZE_BYTE = 2'd0;
  localparam logic [1:0] SIZE_WORD = 2'd2;

  // register offsets in the peripheral window
  localparam logic [15:0] OFF_DATA = 16'h0000;  // rbr / thr / dll
  localparam logic [15:0] OFF_IER  = 16'h0004;  // ier / dlm
  localparam logic [15:0] OFF_IIR  = 16'h0008;  // iir / fcr
  localparam logic [15:0] OFF_LCR  = 16'h000C;
  localparam logic [15:0] OFF_MCR  = 16'h0010;
  localparam logic [15:0] OFF_LSR  = 16'h0014;

  localparam int unsigned DLAB_BIT = 7;
  localparam logic [7:0] LSR_BASE     = 8'h60;
  localparam logic [7:0] IER_RESERVED = 8'hF0;
  localparam logic [7:0] FCR_ALLOWED  = 8'h06;

  // interrupt identification codes
  localparam logic [7:0] IIR_RX_DATA = 8'd4;
  localparam logic [7:0] IIR_TX_EMPTY = 8'd2;
  localparam logic [7:0] IIR_NONE    = 8'd1;

  // stream widths, padded to whole bytes
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned IN_TUSER_W  = 2;
  localparam int unsigned OUT_TDATA_W = 24;

  typedef struct packed {
    logic [7:0]  rx_byte;
    logic [7:0]  write_data;
    logic [15:0] reg_offset;
    logic [1:0]  access_size;
    logic [1:0]  req_type;
  } req_t;

  typedef struct packed {
    logic       protocol_error;
    logic       bad_access;
    logic       irq_line;
    logic [7:0] tx_byte;
    logic       tx_valid;
    logic [7:0] read_data;
  } rsp_t;

endpackage

/* hdl/uart_register_model_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_register_model_core
// reduced 16550-style uart register block on stream channels
// ----------------------------------------------------------------------------
// usage
//   input channel (in_*): one beat is one request - a bus read, a byte or
//   word bus write, or the arrival of a received character. the request
//   kind rides on in_tuser, everything else on in_tdata.
//   result channel (out_*): exactly one beat per request, carrying the read
//   data, the transmitted character if any, the interrupt line after the
//   request and the bad-access and protocol-error flags.
//   path: an accepted request is captured in the input register, decoded
//   combinationally from there, and its result beat is written into the
//   result register, from which it is offered to the receiver.
//   throughput: one request per cycle while out_tready is high, with a
//   combinational decode between the input register and the result register.
//   reset: rst_n low at a clock edge empties both stages and clears every
//   uart register (divisor, ier, lcr, receive buffer and the ready flags).
//   stall: while out_tready is low the result register holds its beat; the
//   input register still takes one more beat, then in_tready drops until
//   the result is taken. nothing is lost or repeated.
// ----------------------------------------------------------------------------
module uart_register_model_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // access_size[1:0], reg_offset[17:2], write_data[25:18], rx_byte[33:26], zero pad
  input  logic [uart_rm_pkg::IN_TDATA_W-1:0]  in_tdata,
  // req_type[1:0]
  input  logic [uart_rm_pkg::IN_TUSER_W-1:0]  in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // read_data[7:0], tx_valid[8], tx_byte[16:9], irq_line[17], bad_access[18],
  // protocol_error[19], zero pad
  output logic [uart_rm_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import uart_rm_pkg::*;

  localparam int unsigned RSP_W = $bits(rsp_t);

  // input register
  logic s1_valid_r, s1_valid_nxt;
  req_t s1_req_r;
  req_t in_req;

  // result register
  logic out_valid_r, out_valid_nxt;
  rsp_t out_rsp_r;

  logic in_fire;
  logic advance;   // s1 beat moves into the result register
  rsp_t exec_rsp;

  // unpack the incoming beat
  assign in_req.req_type    = in_tuser[1:0];
  assign in_req.access_size = in_tdata[1:0];
  assign in_req.reg_offset  = in_tdata[17:2];
  assign in_req.write_data  = in_tdata[25:18];
  assign in_req.rx_byte     = in_tdata[33:26];

  assign advance      = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready    = !s1_valid_r || advance;
  assign in_fire      = in_tvalid && in_tready;
  assign s1_valid_nxt = in_fire || (s1_valid_r && !advance);
  assign out_valid_nxt = advance || (out_valid_r && !out_tready);

  // register state updates in step with the beat leaving s1
  uart_rm_exec u_exec (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_fire (advance),
    .req       (s1_req_r),
    .rsp       (exec_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_req_r <= in_req;
    end
    if (advance) begin
      out_rsp_r <= exec_rsp;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - RSP_W){1'b0}}, out_rsp_r};

endmodule

/* hdl/uart_rm_exec.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_rm_exec
// uart register state and the combinational decode of one request
// ----------------------------------------------------------------------------
module uart_rm_exec (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              item_fire,
  input  uart_rm_pkg::req_t req,
  output uart_rm_pkg::rsp_t rsp
);
  import uart_rm_pkg::*;

  logic [7:0] rx_holding_r, rx_holding_nxt;
  logic       rx_ready_r, rx_ready_nxt;
  logic       tx_ready_r, tx_ready_nxt;
  logic [7:0] div_low_r, div_low_nxt;
  logic [7:0] div_high_r, div_high_nxt;
  logic [7:0] int_enable_r, int_enable_nxt;
  logic [7:0] line_ctrl_r, line_ctrl_nxt;

  logic dlab;
  logic rd_size_ok;

  assign dlab       = line_ctrl_r[DLAB_BIT];
  assign rd_size_ok = (req.access_size == SIZE_BYTE) || (req.access_size == SIZE_WORD);

  always_comb begin
    rx_holding_nxt = rx_holding_r;
    rx_ready_nxt   = rx_ready_r;
    tx_ready_nxt   = tx_ready_r;
    div_low_nxt    = div_low_r;
    div_high_nxt   = div_high_r;
    int_enable_nxt = int_enable_r;
    line_ctrl_nxt  = line_ctrl_r;

    rsp = '0;

    case (req.req_type)
      REQ_READ: begin
        if (!rd_size_ok) begin
          rsp.bad_access = 1'b1;
        end else begin
          case (req.reg_offset)
            OFF_DATA: begin
              if (dlab) begin
                rsp.read_data = div_low_r;
              end else begin
                rsp.protocol_error = !rx_ready_r;
                rx_ready_nxt       = 1'b0;
                rsp.read_data      = rx_holding_r;
              end
            end
            OFF_IER: begin
              rsp.read_data = dlab ? div_high_r : int_enable_r;
            end
            OFF_IIR: begin
              if (rx_ready_r) begin
                rsp.read_data = IIR_RX_DATA;
              end else if (tx_ready_r) begin
                tx_ready_nxt  = 1'b0;
                rsp.read_data = IIR_TX_EMPTY;
              end else begin
                rsp.read_data = IIR_NONE;
              end
            end
            OFF_LCR: begin
              rsp.read_data = line_ctrl_r;
            end
            OFF_LSR: begin
              rsp.read_data = LSR_BASE | {7'd0, rx_ready_r};
            end
            default: begin
              rsp.bad_access = 1'b1;
            end
          endcase
        end
      end
      REQ_WRITE: begin
        if (req.access_size != SIZE_BYTE) begin
          rsp.bad_access = 1'b1;
        end else begin
          case (req.reg_offset)
            OFF_DATA: begin
              if (dlab) begin
                div_low_nxt = req.write_data;
              end else begin
                rsp.tx_valid = 1'b1;
                rsp.tx_byte  = req.write_data;
                tx_ready_nxt = 1'b1;
              end
            end
            OFF_IER: begin
              if (dlab) begin
                div_high_nxt = req.write_data;
              end else begin
                rsp.protocol_error = |(req.write_data & IER_RESERVED);
                int_enable_nxt     = req.write_data;
              end
            end
            OFF_IIR: begin
              // fcr: checked only, nothing stored
              rsp.protocol_error = |(req.write_data & ~FCR_ALLOWED);
            end
            OFF_LCR: begin
              line_ctrl_nxt = req.write_data;
            end
            OFF_MCR: begin
              // accepted and ignored
            end
            default: begin
              rsp.bad_access = 1'b1;
            end
          endcase
        end
      end
      REQ_RX: begin
        // a new byte simply overwrites any unread one
        rx_holding_nxt = req.rx_byte;
        rx_ready_nxt   = 1'b1;
      end
      default: begin
        // unknown request kind leaves everything alone
      end
    endcase

    rsp.irq_line = rx_ready_nxt | tx_ready_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_holding_r <= '0;
      rx_ready_r   <= 1'b0;
      tx_ready_r   <= 1'b0;
      div_low_r    <= '0;
      div_high_r   <= '0;
      int_enable_r <= '0;
      line_ctrl_r  <= '0;
    end else if (item_fire) begin
      rx_holding_r <= rx_holding_nxt;
      rx_ready_r   <= rx_ready_nxt;
      tx_ready_r   <= tx_ready_nxt;
      div_low_r    <= div_low_nxt;
      div_high_r   <= div_high_nxt;
      int_enable_r <= int_enable_nxt;
      line_ctrl_r  <= line_ctrl_nxt;
    end
  end

endmodule

/* hdl/uart_rm_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_rm_checker
// port-level checks on the uart register block result stream
// ----------------------------------------------------------------------------
module uart_rm_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_tvalid,
  input logic                                in_tready,
  input logic [uart_rm_pkg::IN_TDATA_W-1:0]  in_tdata,
  input logic [uart_rm_pkg::IN_TUSER_W-1:0]  in_tuser,
  input logic                                out_tvalid,
  input logic                                out_tready,
  input logic [uart_rm_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import uart_rm_pkg::*;

  rsp_t rsp;
  logic unused_in;

  assign rsp       = out_tdata[$bits(rsp_t)-1:0];
  assign unused_in = in_tvalid & in_tready & (|in_tdata) & (|in_tuser);

  // stalled result beat holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  // a rejected access neither reads nor transmits
  a_bad_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && rsp.bad_access |->
      rsp.read_data == 8'd0 && !rsp.tx_valid && !rsp.protocol_error)
    else $error("bad access produced data or error");

  // a thr write sets tx_ready so the interrupt must be up
  a_tx_irq: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && rsp.tx_valid |-> rsp.irq_line)
    else $error("transmit without interrupt");

  // no character unless one is sent
  a_tx_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !rsp.tx_valid |-> rsp.tx_byte == 8'd0)
    else $error("tx_byte set without tx_valid");

  // padding bits stay clear
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[OUT_TDATA_W-1:$bits(rsp_t)] == '0 || unused_in)
    else $error("result padding not zero");

endmodule

bind uart_register_model_core uart_rm_checker u_uart_rm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
